FILE: rtl/pser_pkg.sv
package pser_pkg;

  // Default sizes of the block.
  localparam int unsigned MAX_K_DEF      = 65536;
  localparam int unsigned PRIME_BITS_DEF = 62;

  // Fixed port widths.
  localparam int unsigned PRIME_W = 62;
  localparam int unsigned INDEX_W = 16;
  localparam int unsigned COUNT_W = 17;
  localparam int unsigned BASE_W  = 31;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned CFG_IDX_W = 3;

  // Operation codes.
  localparam logic [1:0] OP_SIEVE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BASE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXP_N   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_K_MIN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_K_COUNT = 3'd4;

  // Operand pairs of the modular multiplier.
  localparam logic [1:0] MM_PRPB  = 2'd0;  // power result times power base
  localparam logic [1:0] MM_PBPB  = 2'd1;  // power base squared
  localparam logic [1:0] MM_RESBM = 2'd2;  // running residue times base

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       cap;
    logic       rem_go;
    logic       rem_sel;
    logic       rem_step;
    logic       rem_wb;
    logic       pow_go;
    logic       pow_sel;
    logic       pow_shift;
    logic       tgt_set;
    logic       res_set;
    logic       mm_go;
    logic [1:0] mm_src;
    logic       mm_step;
    logic       mm_wb;
    logic [1:0] mm_dst;
    logic       mem_we;
    logic       mem_wd;
    logic       cmp;
    logic       bit_cap;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic p_small;
    logic e_zero;
    logic e_lsb;
    logic mm_done;
  } sts_t;

endpackage

FILE: rtl/prime_sieve_exponent_residue.sv
// Exponent residue sieve over a bitmap of candidate exponents k.
// Items come in on a command channel: an item beat is taken at a rising edge
// with start_i high and busy_o low. A sieve item (op 0) with prime p >= 2
// clears every candidate k = k_min + i, for i below min(k_count, MAX_K),
// whose b^k mod p equals (b^n - c) mod p and reports the number cleared; a
// read item (op 1) returns one bitmap bit; a write item (op 2) stores one.
// Each item gives one result beat: done_o is high for one cycle with
// removed_count_o and candidate_bit_o, and the receiver cannot stall it.
// busy_o stays high until that beat has been shown. A read passes S_RBIT
// then S_DONE, a write goes straight to S_DONE, and the block is idle again
// after each result beat. A sieve item reduces b and c modulo p, forms b^n
// and b^k_min with one or two modular multiplies per bit of n and of k_min,
// then walks the bitmap with one multiply per entry; the bit-serial modular
// multiplier takes one multiplier bit per cycle. After reset the bitmap is
// set to all ones by a sweep over all MAX_K entries with busy_o high.
// Configuration writes on cfg_we_i take effect at once; the user makes them
// only while the block is idle, and the block itself does not enforce this.
module prime_sieve_exponent_residue #(
  parameter int unsigned MAX_K      = pser_pkg::MAX_K_DEF,
  parameter int unsigned PRIME_BITS = pser_pkg::PRIME_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic [1:0]                       op_i,
  input  logic [pser_pkg::PRIME_W-1:0]     prime_i,
  input  logic [pser_pkg::INDEX_W-1:0]     k_index_i,
  input  logic                             bit_value_i,
  output logic                             done_o,
  output logic [pser_pkg::COUNT_W-1:0]     removed_count_o,
  output logic                             candidate_bit_o,
  input  logic                             cfg_we_i,
  input  logic [pser_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [pser_pkg::WORD_W-1:0]      cfg_data_i
);

  localparam int unsigned AW = $clog2(MAX_K);

  logic [pser_pkg::BASE_W-1:0]  base_q;
  logic [pser_pkg::WORD_W-1:0]  exp_n_q, offset_c_q, k_min_q;
  logic [pser_pkg::COUNT_W-1:0] k_count_q;
  pser_pkg::cmd_t cmd;
  pser_pkg::sts_t sts;
  logic [AW-1:0] mem_addr;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q     <= pser_pkg::BASE_W'(2);
      exp_n_q    <= pser_pkg::WORD_W'(1);
      offset_c_q <= pser_pkg::WORD_W'(1);
      k_min_q    <= '0;
      k_count_q  <= pser_pkg::COUNT_W'(65536);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pser_pkg::CFG_BASE:    base_q     <= cfg_data_i[pser_pkg::BASE_W-1:0];
        pser_pkg::CFG_EXP_N:   exp_n_q    <= cfg_data_i;
        pser_pkg::CFG_OFFSET:  offset_c_q <= cfg_data_i;
        pser_pkg::CFG_K_MIN:   k_min_q    <= cfg_data_i;
        pser_pkg::CFG_K_COUNT: k_count_q  <= cfg_data_i[pser_pkg::COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  pser_ctrl #(
    .MAX_K (MAX_K)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .op_i        (op_i),
    .k_index_i   (k_index_i),
    .bit_value_i (bit_value_i),
    .k_count_i   (k_count_q),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .mem_addr_o  (mem_addr),
    .busy_o      (busy_o),
    .done_o      (done_o)
  );

  pser_dp #(
    .MAX_K      (MAX_K),
    .PRIME_BITS (PRIME_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .mem_addr_i      (mem_addr),
    .prime_i         (prime_i),
    .base_i          (base_q),
    .exp_n_i         (exp_n_q),
    .offset_c_i      (offset_c_q),
    .k_min_i         (k_min_q),
    .removed_count_o (removed_count_o),
    .candidate_bit_o (candidate_bit_o)
  );

endmodule

FILE: rtl/pser_dp.sv
module pser_dp #(
  parameter int unsigned MAX_K      = pser_pkg::MAX_K_DEF,
  parameter int unsigned PRIME_BITS = pser_pkg::PRIME_BITS_DEF,
  localparam int unsigned AW = $clog2(MAX_K),
  localparam int unsigned PW = (PRIME_BITS < pser_pkg::PRIME_W) ? PRIME_BITS
                                                                  : pser_pkg::PRIME_W
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pser_pkg::cmd_t                cmd_i,
  output pser_pkg::sts_t                sts_o,
  input  logic [AW-1:0]                 mem_addr_i,
  input  logic [pser_pkg::PRIME_W-1:0]  prime_i,
  input  logic [pser_pkg::BASE_W-1:0]   base_i,
  input  logic [pser_pkg::WORD_W-1:0]   exp_n_i,
  input  logic [pser_pkg::WORD_W-1:0]   offset_c_i,
  input  logic [pser_pkg::WORD_W-1:0]   k_min_i,
  output logic [pser_pkg::COUNT_W-1:0]  removed_count_o,
  output logic                          candidate_bit_o
);

  logic [PW-1:0] p_q, rem_q, bm_q, cm_q, pr_q, pb_q, tgt_q, res_q;
  logic [PW-1:0] r_q, a_q, b_q;
  logic [pser_pkg::WORD_W-1:0] dsr_q, e_q;
  logic [pser_pkg::COUNT_W-1:0] cnt_q;
  logic bit_q, rdata_q;
  logic [PW:0] rem_sh;
  logic [PW-1:0] rem_next, neg_cm, mm_a, mm_b;
  logic hit;

  logic map_q [MAX_K];

  // Sum of two residues reduced once.
  function automatic logic [PW-1:0] add_mod(input logic [PW-1:0] x,
                                            input logic [PW-1:0] y,
                                            input logic [PW-1:0] m);
    logic [PW:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[PW-1:0];
  endfunction

  // One restoring step of the remainder unit.
  assign rem_sh   = {rem_q, dsr_q[pser_pkg::WORD_W-1]};
  assign rem_next = (rem_sh >= {1'b0, p_q}) ? PW'(rem_sh - {1'b0, p_q}) : rem_sh[PW-1:0];
  assign neg_cm   = (cm_q == '0) ? '0 : p_q - cm_q;

  // Operands of the multiplier by pair code.
  always_comb begin
    case (cmd_i.mm_src)
      pser_pkg::MM_PRPB: begin
        mm_a = pr_q;
        mm_b = pb_q;
      end
      pser_pkg::MM_PBPB: begin
        mm_a = pb_q;
        mm_b = pb_q;
      end
      pser_pkg::MM_RESBM: begin
        mm_a = res_q;
        mm_b = bm_q;
      end
      default: begin
        mm_a = '0;
        mm_b = '0;
      end
    endcase
  end

  assign hit = rdata_q & (res_q == tgt_q);

  // Arithmetic registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      p_q <= prime_i[PW-1:0];
    end
    if (cmd_i.rem_go) begin
      rem_q <= '0;
      dsr_q <= cmd_i.rem_sel ? offset_c_i : {1'b0, base_i};
    end else if (cmd_i.rem_step) begin
      rem_q <= rem_next;
      dsr_q <= {dsr_q[pser_pkg::WORD_W-2:0], 1'b0};
    end
    if (cmd_i.rem_wb) begin
      if (cmd_i.rem_sel) begin
        cm_q <= rem_next;
      end else begin
        bm_q <= rem_next;
      end
    end
    if (cmd_i.pow_go) begin
      pr_q <= PW'(1);
      pb_q <= bm_q;
      e_q  <= cmd_i.pow_sel ? k_min_i : exp_n_i;
    end else begin
      if (cmd_i.pow_shift) begin
        e_q <= e_q >> 1;
      end
      if (cmd_i.mm_wb && cmd_i.mm_dst == pser_pkg::MM_PRPB) begin
        pr_q <= r_q;
      end
      if (cmd_i.mm_wb && cmd_i.mm_dst == pser_pkg::MM_PBPB) begin
        pb_q <= r_q;
      end
    end
    if (cmd_i.tgt_set) begin
      tgt_q <= add_mod(pr_q, neg_cm, p_q);
    end
    if (cmd_i.res_set) begin
      res_q <= pr_q;
    end else if (cmd_i.mm_wb && cmd_i.mm_dst == pser_pkg::MM_RESBM) begin
      res_q <= r_q;
    end
    // Shift-and-add modular multiplier, one multiplier bit per cycle.
    if (cmd_i.mm_go) begin
      r_q <= '0;
      a_q <= mm_a;
      b_q <= mm_b;
    end else if (cmd_i.mm_step) begin
      if (b_q[0]) begin
        r_q <= add_mod(r_q, a_q, p_q);
      end
      a_q <= add_mod(a_q, a_q, p_q);
      b_q <= b_q >> 1;
    end
  end

  // Result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      bit_q <= 1'b0;
    end else if (cmd_i.cap) begin
      cnt_q <= '0;
      bit_q <= 1'b0;
    end else begin
      if (cmd_i.cmp && hit) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.bit_cap) begin
        bit_q <= rdata_q;
      end
    end
  end

  // Candidate bitmap, one port with registered read.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_we || (cmd_i.cmp && hit)) begin
      map_q[mem_addr_i] <= cmd_i.cmp ? 1'b0 : cmd_i.mem_wd;
    end
    rdata_q <= map_q[mem_addr_i];
  end

  assign sts_o.p_small = (prime_i[PW-1:1] == '0);
  assign sts_o.e_zero  = (e_q == '0);
  assign sts_o.e_lsb   = e_q[0];
  assign sts_o.mm_done = (b_q == '0);

  assign removed_count_o = cnt_q;
  assign candidate_bit_o = bit_q;

endmodule

FILE: rtl/pser_ctrl.sv
module pser_ctrl #(
  parameter int unsigned MAX_K = pser_pkg::MAX_K_DEF,
  localparam int unsigned AW = $clog2(MAX_K),
  localparam int unsigned CW = $clog2(MAX_K + 1)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [1:0]                     op_i,
  input  logic [pser_pkg::INDEX_W-1:0]   k_index_i,
  input  logic                           bit_value_i,
  input  logic [pser_pkg::COUNT_W-1:0]   k_count_i,
  input  pser_pkg::sts_t                 sts_i,
  output pser_pkg::cmd_t                 cmd_o,
  output logic [AW-1:0]                  mem_addr_o,
  output logic                           busy_o,
  output logic                           done_o
);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_REM  = 4'd2;
  localparam logic [3:0] S_RGO  = 4'd3;
  localparam logic [3:0] S_PGO  = 4'd4;
  localparam logic [3:0] S_PCHK = 4'd5;
  localparam logic [3:0] S_MM   = 4'd6;
  localparam logic [3:0] S_PEND = 4'd7;
  localparam logic [3:0] S_WRD  = 4'd8;
  localparam logic [3:0] S_WCMP = 4'd9;
  localparam logic [3:0] S_RBIT = 4'd10;
  localparam logic [3:0] S_DONE = 4'd11;

  logic [3:0] state_q, state_d;
  logic [CW-1:0] i_q, i_d, limit, i_inc;
  logic [4:0] j_q, j_d;
  logic rsel_q, rsel_d, psel_q, psel_d, rng_q, rng_d;
  logic [1:0] msel_q, msel_d;
  logic in_range;

  // Entries walked: the count saturated at the bitmap depth.
  assign limit = ({15'b0, k_count_i} > 32'(MAX_K)) ? CW'(MAX_K) : CW'(k_count_i);
  assign i_inc = i_q + CW'(1);
  assign in_range = ({16'b0, k_index_i} < 32'(MAX_K));

  // Sequencer.
  always_comb begin
    state_d    = state_q;
    i_d        = i_q;
    j_d        = j_q;
    rsel_d     = rsel_q;
    psel_d     = psel_q;
    msel_d     = msel_q;
    rng_d      = rng_q;
    cmd_o      = '0;
    cmd_o.mm_dst = msel_q;
    mem_addr_o = i_q[AW-1:0];
    done_o     = 1'b0;
    case (state_q)
      S_CLR: begin
        cmd_o.mem_we = 1'b1;
        cmd_o.mem_wd = 1'b1;
        i_d = i_inc;
        if (i_q == CW'(MAX_K - 1)) begin
          i_d     = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        mem_addr_o = AW'(k_index_i);
        if (start_i) begin
          cmd_o.cap = 1'b1;
          rng_d = in_range;
          case (op_i)
            pser_pkg::OP_SIEVE: begin
              if (sts_i.p_small) begin
                state_d = S_DONE;
              end else begin
                cmd_o.rem_go = 1'b1;
                rsel_d  = 1'b0;
                j_d     = '0;
                state_d = S_REM;
              end
            end
            pser_pkg::OP_READ: begin
              state_d = S_RBIT;
            end
            pser_pkg::OP_WRITE: begin
              cmd_o.mem_we = in_range;
              cmd_o.mem_wd = bit_value_i;
              state_d = S_DONE;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_REM: begin
        cmd_o.rem_step = 1'b1;
        cmd_o.rem_sel  = rsel_q;
        j_d = j_q + 5'd1;
        if (j_q == 5'd31) begin
          cmd_o.rem_wb = 1'b1;
          if (!rsel_q) begin
            rsel_d  = 1'b1;
            state_d = S_RGO;
          end else begin
            psel_d  = 1'b0;
            state_d = S_PGO;
          end
        end
      end
      S_RGO: begin
        cmd_o.rem_go  = 1'b1;
        cmd_o.rem_sel = 1'b1;
        j_d     = '0;
        state_d = S_REM;
      end
      S_PGO: begin
        cmd_o.pow_go  = 1'b1;
        cmd_o.pow_sel = psel_q;
        state_d = S_PCHK;
      end
      S_PCHK: begin
        if (sts_i.e_zero) begin
          state_d = S_PEND;
        end else begin
          cmd_o.mm_go  = 1'b1;
          cmd_o.mm_src = sts_i.e_lsb ? pser_pkg::MM_PRPB : pser_pkg::MM_PBPB;
          msel_d  = cmd_o.mm_src;
          state_d = S_MM;
        end
      end
      S_MM: begin
        if (sts_i.mm_done) begin
          cmd_o.mm_wb = 1'b1;
          case (msel_q)
            pser_pkg::MM_PRPB: begin
              cmd_o.mm_go  = 1'b1;
              cmd_o.mm_src = pser_pkg::MM_PBPB;
              msel_d = pser_pkg::MM_PBPB;
            end
            pser_pkg::MM_PBPB: begin
              cmd_o.pow_shift = 1'b1;
              state_d = S_PCHK;
            end
            default: begin
              i_d = i_inc;
              state_d = (i_inc == limit) ? S_DONE : S_WRD;
            end
          endcase
        end else begin
          cmd_o.mm_step = 1'b1;
        end
      end
      S_PEND: begin
        if (!psel_q) begin
          cmd_o.tgt_set = 1'b1;
          psel_d  = 1'b1;
          state_d = S_PGO;
        end else begin
          cmd_o.res_set = 1'b1;
          i_d     = '0;
          state_d = (limit == '0) ? S_DONE : S_WRD;
        end
      end
      S_WRD: begin
        state_d = S_WCMP;
      end
      S_WCMP: begin
        cmd_o.cmp    = 1'b1;
        cmd_o.mm_go  = 1'b1;
        cmd_o.mm_src = pser_pkg::MM_RESBM;
        msel_d  = pser_pkg::MM_RESBM;
        state_d = S_MM;
      end
      S_RBIT: begin
        cmd_o.bit_cap = rng_q;
        state_d = S_DONE;
      end
      S_DONE: begin
        done_o  = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      i_q     <= '0;
      j_q     <= '0;
      rsel_q  <= 1'b0;
      psel_q  <= 1'b0;
      msel_q  <= pser_pkg::MM_PRPB;
      rng_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      rsel_q  <= rsel_d;
      psel_q  <= psel_d;
      msel_q  <= msel_d;
      rng_q   <= rng_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

FILE: test/tb.sv
module tb;

  // Spare operation code: the block must ignore it.
  localparam logic [1:0] OP_NONE = 2'd3;
  localparam int unsigned MAP_DEPTH = 65536;
  localparam longint unsigned IDLE_LIMIT = 12_000_000;

  // Predicts the exponent sieve and checks each result beat.
  class residue_board;
    bit                          cand_map[MAP_DEPTH];
    bit [30:0]                   base_b;
    bit [31:0]                   exp_n;
    bit [31:0]                   off_c;
    bit [31:0]                   k_first;
    bit [16:0]                   k_span;
    bit [pser_pkg::COUNT_W-1:0]  want_removed[$];
    bit                          want_bit[$];
    int                          errors;
    int                          sieves;
    int                          cleared;
    int                          bit_ops;

    function new();
      foreach (cand_map[i]) cand_map[i] = 1'b1;
      base_b  = 31'd2;
      exp_n   = 32'd1;
      off_c   = 32'd1;
      k_first = 32'd0;
      k_span  = 17'd65536;
    endfunction

    task report(string what);
      errors++;
      $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    function void set_reg(logic [pser_pkg::CFG_IDX_W-1:0] idx,
                          logic [pser_pkg::WORD_W-1:0] data);
      case (idx)
        pser_pkg::CFG_BASE:    base_b  = data[30:0];
        pser_pkg::CFG_EXP_N:   exp_n   = data;
        pser_pkg::CFG_OFFSET:  off_c   = data;
        pser_pkg::CFG_K_MIN:   k_first = data;
        pser_pkg::CFG_K_COUNT: k_span  = data[16:0];
        default: ;
      endcase
    endfunction

    function bit [61:0] mul_residue(bit [61:0] a, bit [61:0] b, bit [61:0] p);
      bit [127:0] prod;
      prod = a * b;
      return prod % p;
    endfunction

    function bit [61:0] pow_residue(bit [61:0] b, bit [31:0] e, bit [61:0] p);
      bit [61:0] r;
      r = 62'd1 % p;
      while (e != 0) begin
        if (e[0]) r = mul_residue(r, b, p);
        b = mul_residue(b, b, p);
        e = e >> 1;
      end
      return r;
    endfunction

    // Works out the result of one accepted item and queues it.
    function void note_item(logic [1:0] op, logic [61:0] p, logic [15:0] idx, logic v);
      bit [61:0] bm, target, res;
      bit [63:0] sum;
      int unsigned lim, removed;
      bit rd;
      removed = 0;
      rd = 1'b0;
      case (op)
        pser_pkg::OP_SIEVE: begin
          sieves++;
          if (p >= 2) begin
            bm = base_b % p;
            sum = pow_residue(bm, exp_n, p) + ((p - off_c % p) % p);
            target = (sum >= p) ? sum - p : sum;
            res = pow_residue(bm, k_first, p);
            lim = (k_span > MAP_DEPTH) ? MAP_DEPTH : k_span;
            for (int unsigned i = 0; i < lim; i++) begin
              if (cand_map[i] && res == target) begin
                cand_map[i] = 1'b0;
                removed++;
              end
              res = mul_residue(res, bm, p);
            end
          end
          cleared += removed;
        end
        pser_pkg::OP_READ: begin
          bit_ops++;
          rd = cand_map[idx];
        end
        pser_pkg::OP_WRITE: begin
          bit_ops++;
          cand_map[idx] = v;
        end
        default: ;
      endcase
      want_removed.push_back(removed[pser_pkg::COUNT_W-1:0]);
      want_bit.push_back(rd);
    endfunction

    task check_result(logic [pser_pkg::COUNT_W-1:0] removed, logic cbit);
      bit [pser_pkg::COUNT_W-1:0] er;
      bit eb;
      if (want_removed.size() == 0) begin
        report("result beat with no item outstanding");
      end else begin
        er = want_removed.pop_front();
        eb = want_bit.pop_front();
        if (removed !== er)
          report($sformatf("removed_count %0d, expected %0d", removed, er));
        if (cbit !== eb)
          report($sformatf("candidate_bit %b, expected %b", cbit, eb));
      end
    endtask
  endclass

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           start_i = 1'b0;
  logic                           busy_o;
  logic [1:0]                     op_i = pser_pkg::OP_SIEVE;
  logic [pser_pkg::PRIME_W-1:0]   prime_i = '0;
  logic [pser_pkg::INDEX_W-1:0]   k_index_i = '0;
  logic                           bit_value_i = 1'b0;
  logic                           done_o;
  logic [pser_pkg::COUNT_W-1:0]   removed_count_o;
  logic                           candidate_bit_o;
  logic                           cfg_we_i = 1'b0;
  logic [pser_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [pser_pkg::WORD_W-1:0]    cfg_data_i = '0;

  residue_board board = new();
  longint unsigned idle_cycles = 0;

  prime_sieve_exponent_residue u_top (
    .clk_i, .rst_ni, .start_i, .busy_o, .op_i, .prime_i, .k_index_i, .bit_value_i,
    .done_o, .removed_count_o, .candidate_bit_o, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Check every result beat; the watchdog counts cycles with no beat moving.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) board.check_result(removed_count_o, candidate_bit_o);
    if ((start_i && !busy_o) || done_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles > IDLE_LIMIT) begin
      $display("Watchdog expired with %0d results outstanding", board.want_removed.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // Sends one item beat after a random gap; start stays high until the next call.
  task send_item(logic [1:0] op, logic [61:0] p, logic [15:0] idx, logic v);
    int gap;
    gap = $urandom_range(0, 12);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      @(negedge clk_i);
      start_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start_i     <= 1'b1;
    op_i        <= op;
    prime_i     <= p;
    k_index_i   <= idx;
    bit_value_i <= v;
    do @(posedge clk_i); while (busy_o);
    board.note_item(op, p, idx, v);
  endtask

  // Waits until the block is idle and no result is outstanding.
  task drain();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (board.want_removed.size() != 0 || busy_o) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
  endtask

  task write_reg(logic [pser_pkg::CFG_IDX_W-1:0] idx, logic [pser_pkg::WORD_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    board.set_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function logic [61:0] pick_prime();
    logic [61:0] smalls[12] = '{2, 3, 5, 7, 11, 13, 17, 31, 61, 127, 9, 21};
    case ($urandom_range(0, 9))
      0: return {$urandom, $urandom};
      1: return $urandom_range(0, 1);
      2, 3: return $urandom_range(2, 300);
      default: return smalls[$urandom_range(0, 11)];
    endcase
  endfunction

  function logic [15:0] pick_index();
    if ($urandom_range(0, 4) == 0) return $urandom;
    return $urandom_range(0, 70);
  endfunction

  // Random settings with a small walk so each sieve stays short.
  task random_config();
    logic [pser_pkg::WORD_W-1:0] b;
    case ($urandom_range(0, 4))
      0: b = 32'd2;
      1: b = $urandom_range(3, 40);
      2: b = 32'hFFFF_FFFF;
      default: b = $urandom;
    endcase
    write_reg(pser_pkg::CFG_BASE, b);
    write_reg(pser_pkg::CFG_EXP_N,
              ($urandom_range(0, 1) != 0) ? $urandom_range(1, 40) : $urandom);
    write_reg(pser_pkg::CFG_OFFSET,
              ($urandom_range(0, 1) != 0) ? $urandom_range(0, 40) : $urandom);
    write_reg(pser_pkg::CFG_K_MIN,
              ($urandom_range(0, 1) != 0) ? $urandom_range(0, 40) : $urandom);
    write_reg(pser_pkg::CFG_K_COUNT,
              ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 64));
    if ($urandom_range(0, 5) == 0)
      write_reg(pser_pkg::CFG_IDX_W'($urandom_range(5, 7)), $urandom);
  endtask

  initial begin
    int n_items;
    int pick;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    drain();

    // Directed part: edges of the map, small and wide moduli, spare op.
    write_reg(pser_pkg::CFG_K_COUNT, 32'd16);
    send_item(pser_pkg::OP_READ, '0, 16'd0, 1'b0);
    send_item(pser_pkg::OP_READ, '0, 16'hFFFF, 1'b0);
    send_item(pser_pkg::OP_WRITE, '0, 16'hFFFF, 1'b0);
    send_item(pser_pkg::OP_READ, '0, 16'hFFFF, 1'b0);
    send_item(pser_pkg::OP_WRITE, '0, 16'd40, 1'b1);
    send_item(pser_pkg::OP_SIEVE, 62'd0, 16'd0, 1'b0);
    send_item(pser_pkg::OP_SIEVE, 62'd1, 16'd0, 1'b0);
    send_item(pser_pkg::OP_SIEVE, 62'd3, 16'd0, 1'b0);
    send_item(pser_pkg::OP_SIEVE, 62'd2, 16'd0, 1'b0);
    send_item(pser_pkg::OP_SIEVE, 62'd15, 16'd0, 1'b0);
    send_item(pser_pkg::OP_SIEVE, {62{1'b1}}, 16'd0, 1'b0);
    send_item(OP_NONE, {62{1'b1}}, 16'hFFFF, 1'b1);
    send_item(pser_pkg::OP_READ, '0, 16'd1, 1'b0);
    drain();
    write_reg(pser_pkg::CFG_BASE, 32'hFFFF_FFFF);
    write_reg(pser_pkg::CFG_EXP_N, 32'hFFFF_FFFF);
    write_reg(pser_pkg::CFG_OFFSET, 32'hFFFF_FFFF);
    write_reg(pser_pkg::CFG_K_MIN, 32'hFFFF_FFFF);
    write_reg(pser_pkg::CFG_K_COUNT, 32'd0);
    write_reg(3'd7, 32'hFFFF_FFFF);
    send_item(pser_pkg::OP_SIEVE, 62'd7, 16'd0, 1'b0);
    send_item(pser_pkg::OP_SIEVE, 62'd13, 16'd0, 1'b0);
    drain();

    // One walk over the whole map, with the count beyond the map size.
    write_reg(pser_pkg::CFG_BASE, 32'd3);
    write_reg(pser_pkg::CFG_EXP_N, 32'd5);
    write_reg(pser_pkg::CFG_OFFSET, 32'd0);
    write_reg(pser_pkg::CFG_K_MIN, 32'd1);
    write_reg(pser_pkg::CFG_K_COUNT, 32'h0001_FFFF);
    send_item(pser_pkg::OP_SIEVE, 62'd11, 16'd0, 1'b0);
    send_item(pser_pkg::OP_READ, '0, 16'hFFFE, 1'b0);
    drain();

    // Random phases of sieves mixed with single-bit traffic.
    n_items = 0;
    while (n_items < 80) begin
      random_config();
      repeat ($urandom_range(6, 14)) begin
        pick = $urandom_range(0, 19);
        if (pick < 9) begin
          send_item(pser_pkg::OP_SIEVE, pick_prime(), $urandom, $urandom);
        end else if (pick < 14) begin
          send_item(pser_pkg::OP_READ, $urandom, pick_index(), $urandom);
        end else if (pick < 19) begin
          send_item(pser_pkg::OP_WRITE, $urandom, pick_index(), ($urandom_range(0, 3) != 0));
        end else begin
          send_item(OP_NONE, {$urandom, $urandom}, $urandom, $urandom);
        end
        n_items++;
      end
      drain();
    end

    repeat (20) @(posedge clk_i);
    if (board.want_removed.size() != 0)
      board.report($sformatf("%0d results never arrived", board.want_removed.size()));
    $display("Covered %0d sieve items clearing %0d candidates and %0d bit reads or writes.",
             board.sieves, board.cleared, board.bit_ops);
    if (board.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/pser_pkg.sv
rtl/pser_dp.sv
rtl/pser_ctrl.sv
rtl/prime_sieve_exponent_residue.sv
test/tb.sv
